// ===== design/kcdt_pkg.sv =====
`timescale 1ns / 1ps

package kcdt_pkg;

  localparam int DEFAULT_NUM_SLOTS = 8;
  localparam int DEFAULT_KEY_WIDTH = 32;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_LIST = 2'd2;

  localparam logic REG_MAX_ACTIVE       = 1'b0;
  localparam logic REG_TICKS_PER_SECOND = 1'b1;

  localparam logic [3:0]  MAX_ACTIVE_RESET       = 4'd1;
  localparam logic [3:0]  MAX_ACTIVE_LOW         = 4'd1;
  localparam logic [3:0]  MAX_ACTIVE_HIGH        = 4'd8;
  localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd100;

  typedef enum logic [2:0] {
    KIND_CREATED = 3'd0,
    KIND_UPDATED = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_EXPIRED = 3'd3,
    KIND_ENTRY   = 3'd4,
    KIND_EMPTY   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [3:0]  max_active;
    logic [15:0] ticks_per_second;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  slot;
    logic [31:0] key_out;
    logic [15:0] remaining;
  } res_t;

endpackage

// ===== design/keyed_countdown_timer_bank_core.sv =====
`timescale 1ns / 1ps

// Bank of keyed one-shot countdown timers.
// Command channel: an item (op, key, seconds) is taken when start is high
// and busy is low; busy stays high while the item sweeps the slots.
// Ops: set a timer by key, advance all timers by one tick, list timers.
// Config: wr_en with wr_index/wr_data writes max_active or
// ticks_per_second; write only while busy is low.
// Results appear for one cycle each with strobe high; last marks the final
// result of the item. The receiver cannot stall the block.
// Each item sweeps the slot memory one slot per cycle through its single
// read port. busy stays high while set and list sweep the first max_active
// slots and while tick sweeps all NUM_SLOTS, and a new item is taken only
// once busy is low again. The final result of an item, the only one for
// set, appears in the first cycle after busy falls; earlier tick and list
// results come out while busy, each one held back until the next is found
// so that last can be marked.
// A tick that expires nothing gives no result; an unknown op is taken and
// dropped without raising busy.
// Reset clears all slots to inactive and restores max_active = 1 and
// ticks_per_second = 100; no memory clearing pass is needed.

module keyed_countdown_timer_bank_core import kcdt_pkg::*; #(
  parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS,
  parameter int KEY_WIDTH = DEFAULT_KEY_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] key,
  input  logic [15:0] seconds,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic [2:0]  slot,
  output logic [31:0] key_out,
  output logic [15:0] remaining,
  output logic        last
);

  localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ENTRY_W = KEY_WIDTH + 32;

  cfg_t               cfg;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  res_t               res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_active       <= MAX_ACTIVE_RESET;
      cfg.ticks_per_second <= TICKS_PER_SECOND_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_MAX_ACTIVE: begin
          if (wr_data[3:0] >= MAX_ACTIVE_LOW && wr_data[3:0] <= MAX_ACTIVE_HIGH &&
              int'(wr_data[3:0]) <= NUM_SLOTS) begin
            cfg.max_active <= wr_data[3:0];
          end
        end
        REG_TICKS_PER_SECOND: begin
          if (wr_data != 16'd0) begin
            cfg.ticks_per_second <= wr_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  kcdt_slot_mem #(
    .DEPTH  (NUM_SLOTS),
    .WIDTH  (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  kcdt_seq #(
    .NUM_SLOTS (NUM_SLOTS),
    .KEY_WIDTH (KEY_WIDTH),
    .IDX_W     (IDX_W),
    .ENTRY_W   (ENTRY_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op_in      (op),
    .key_in     (key),
    .seconds_in (seconds),
    .cfg        (cfg),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (strobe),
    .res        (res),
    .res_last   (last)
  );

  assign kind      = res.kind;
  assign slot      = res.slot;
  assign key_out   = res.key_out;
  assign remaining = res.remaining;

endmodule

// ===== design/kcdt_slot_mem.sv =====
`timescale 1ns / 1ps

module kcdt_slot_mem #(
  parameter int DEPTH  = 8,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/kcdt_seq.sv =====
`timescale 1ns / 1ps

module kcdt_seq import kcdt_pkg::*; #(
  parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS,
  parameter int KEY_WIDTH = DEFAULT_KEY_WIDTH,
  parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  parameter int ENTRY_W   = KEY_WIDTH + 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_in,
  input  logic [31:0]        key_in,
  input  logic [15:0]        seconds_in,
  input  cfg_t               cfg,
  output logic               mem_we,
  output logic [IDX_W-1:0]   mem_waddr,
  output logic [ENTRY_W-1:0] mem_wdata,
  output logic               mem_re,
  output logic [IDX_W-1:0]   mem_raddr,
  input  logic [ENTRY_W-1:0] mem_rdata,
  output logic               res_valid,
  output res_t               res,
  output logic               res_last
);

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                 state, state_next;
  logic [1:0]             op_q, op_q_next;
  logic [KEY_WIDTH-1:0]   key_q, key_q_next;
  logic [15:0]            secs_q, secs_q_next;
  logic [CNT_W-1:0]       rd_cnt, rd_cnt_next;
  logic [CNT_W-1:0]       lim, lim_next;
  logic                   pv, pv_next;
  logic [IDX_W-1:0]       pidx, pidx_next;
  logic                   match_found, match_found_next;
  logic [IDX_W-1:0]       match_idx, match_idx_next;
  logic                   free_found, free_found_next;
  logic [IDX_W-1:0]       free_idx, free_idx_next;
  logic                   pend_valid, pend_valid_next;
  res_t                   pend, pend_next;
  logic [NUM_SLOTS-1:0]   active, active_next;
  logic                   res_valid_next;
  res_t                   res_next;
  logic                   res_last_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    logic [KEY_WIDTH-1:0] e_key;
    logic [15:0]          e_secs;
    logic [15:0]          e_sub;
    logic [16:0]          cnt_inc;
    logic [15:0]          new_secs;
    logic [15:0]          new_sub;
    logic                 fire;
    logic                 push;
    res_t                 new_res;

    e_key    = mem_rdata[ENTRY_W-1:32];
    e_secs   = mem_rdata[31:16];
    e_sub    = mem_rdata[15:0];
    cnt_inc  = {1'b0, e_sub} + 17'd1;
    new_secs = e_secs;
    new_sub  = e_sub;
    fire     = 1'b0;
    push     = 1'b0;
    new_res  = '0;

    state_next       = state;
    op_q_next        = op_q;
    key_q_next       = key_q;
    secs_q_next      = secs_q;
    rd_cnt_next      = rd_cnt;
    lim_next         = lim;
    pv_next          = pv;
    pidx_next        = pidx;
    match_found_next = match_found;
    match_idx_next   = match_idx;
    free_found_next  = free_found;
    free_idx_next    = free_idx;
    pend_valid_next  = pend_valid;
    pend_next        = pend;
    active_next      = active;
    res_valid_next   = 1'b0;
    res_next         = res;
    res_last_next    = res_last;

    mem_we    = 1'b0;
    mem_waddr = pidx;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = rd_cnt[IDX_W-1:0];

    case (state)
      ST_IDLE: begin
        if (start) begin
          op_q_next        = op_in;
          key_q_next       = KEY_WIDTH'(key_in);
          secs_q_next      = seconds_in;
          rd_cnt_next      = '0;
          lim_next         = (op_in == OP_TICK) ? CNT_W'(NUM_SLOTS) : CNT_W'(cfg.max_active);
          pv_next          = 1'b0;
          match_found_next = 1'b0;
          free_found_next  = 1'b0;
          pend_valid_next  = 1'b0;
          if (op_in == OP_SET || op_in == OP_TICK || op_in == OP_LIST) begin
            state_next = ST_RUN;
          end
        end
      end

      ST_RUN: begin
        if (rd_cnt < lim) begin
          mem_re      = 1'b1;
          pv_next     = 1'b1;
          pidx_next   = rd_cnt[IDX_W-1:0];
          rd_cnt_next = rd_cnt + CNT_W'(1);
        end else begin
          pv_next = 1'b0;
        end

        if (pv && active[pidx]) begin
          case (op_q)
            OP_SET: begin
              if (e_key == key_q && !match_found) begin
                match_found_next = 1'b1;
                match_idx_next   = pidx;
              end
            end
            OP_TICK: begin
              if (e_secs == 16'd0) begin
                fire = 1'b1;
              end else if (cnt_inc >= {1'b0, cfg.ticks_per_second}) begin
                new_sub  = 16'd0;
                new_secs = e_secs - 16'd1;
                fire     = (new_secs == 16'd0);
              end else begin
                new_sub = cnt_inc[15:0];
              end
              mem_we    = 1'b1;
              mem_waddr = pidx;
              mem_wdata = {e_key, new_secs, new_sub};
              if (fire) begin
                active_next[pidx] = 1'b0;
                push              = 1'b1;
                new_res.kind      = KIND_EXPIRED;
                new_res.slot      = 3'(pidx);
                new_res.key_out   = 32'(e_key);
                new_res.remaining = 16'd0;
              end
            end
            OP_LIST: begin
              push              = 1'b1;
              new_res.kind      = KIND_ENTRY;
              new_res.slot      = 3'(pidx);
              new_res.key_out   = 32'(e_key);
              new_res.remaining = e_secs;
            end
            default: begin
            end
          endcase
        end

        if (pv && !active[pidx] && op_q == OP_SET && !free_found) begin
          free_found_next = 1'b1;
          free_idx_next   = pidx;
        end

        if (push) begin
          if (pend_valid) begin
            res_valid_next = 1'b1;
            res_next       = pend;
            res_last_next  = 1'b0;
          end
          pend_next       = new_res;
          pend_valid_next = 1'b1;
        end

        if (rd_cnt == lim && !pv) begin
          state_next = ST_FIN;
        end
      end

      ST_FIN: begin
        state_next    = ST_IDLE;
        res_last_next = 1'b1;
        res_next      = '0;
        case (op_q)
          OP_SET: begin
            res_valid_next   = 1'b1;
            res_next.key_out = 32'(key_q);
            mem_wdata        = {key_q, secs_q, 16'd0};
            if (match_found) begin
              mem_we        = 1'b1;
              mem_waddr     = match_idx;
              res_next.kind = KIND_UPDATED;
              res_next.slot = 3'(match_idx);
            end else if (free_found) begin
              mem_we                 = 1'b1;
              mem_waddr              = free_idx;
              active_next[free_idx]  = 1'b1;
              res_next.kind          = KIND_CREATED;
              res_next.slot          = 3'(free_idx);
            end else begin
              res_next.kind = KIND_FULL;
            end
          end
          OP_TICK: begin
            if (pend_valid) begin
              res_valid_next = 1'b1;
              res_next       = pend;
            end
          end
          OP_LIST: begin
            res_valid_next = 1'b1;
            if (pend_valid) begin
              res_next = pend;
            end else begin
              res_next.kind = KIND_EMPTY;
            end
          end
          default: begin
          end
        endcase
        pend_valid_next = 1'b0;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pv         <= 1'b0;
      pend_valid <= 1'b0;
      active     <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pv         <= pv_next;
      pend_valid <= pend_valid_next;
      active     <= active_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q        <= op_q_next;
    key_q       <= key_q_next;
    secs_q      <= secs_q_next;
    rd_cnt      <= rd_cnt_next;
    lim         <= lim_next;
    pidx        <= pidx_next;
    match_found <= match_found_next;
    match_idx   <= match_idx_next;
    free_found  <= free_found_next;
    free_idx    <= free_idx_next;
    pend        <= pend_next;
    res         <= res_next;
    res_last    <= res_last_next;
  end

endmodule
